>>> rtl/bra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types and codes of the bitmap range allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

	localparam int IDX_W  = 11;
	localparam int CNT_W  = IDX_W + 1;
	localparam int MODE_W = 4;
	localparam int STAT_W = 2;

	localparam logic [MODE_W-1:0] MODE_SET_BIT   = 4'd0;
	localparam logic [MODE_W-1:0] MODE_FLIP_BIT  = 4'd1;
	localparam logic [MODE_W-1:0] MODE_TEST_BIT  = 4'd2;
	localparam logic [MODE_W-1:0] MODE_SET_RANGE = 4'd3;
	localparam logic [MODE_W-1:0] MODE_COUNT     = 4'd4;
	localparam logic [MODE_W-1:0] MODE_CONTAINS  = 4'd5;
	localparam logic [MODE_W-1:0] MODE_FIRST_FIT = 4'd6;
	localparam logic [MODE_W-1:0] MODE_BEST_FIT  = 4'd7;
	localparam logic [MODE_W-1:0] MODE_ALLOC     = 4'd8;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_NONE   = 2'd1;
	localparam logic [STAT_W-1:0] ST_BOUNDS = 2'd2;

	localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_DIVQ,
		S_DIVR,
		S_FETCH,
		S_LOAD,
		S_STEP,
		S_DONE
	} state_t;

endpackage

>>> rtl/bra_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_if
// Request and response channels of the bitmap range allocator.
// ----------------------------------------------------------------------------
interface bra_req_if;
	logic                       valid;
	logic                       ready;
	logic [bra_pkg::MODE_W-1:0] mode;
	logic [bra_pkg::IDX_W-1:0]  position;
	logic [bra_pkg::IDX_W-1:0]  length;
	logic                       bit_value;

	modport source (output valid, mode, position, length, bit_value, input ready);
	modport sink   (input valid, mode, position, length, bit_value, output ready);
endinterface

interface bra_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [bra_pkg::IDX_W-1:0]  found_index;
	logic [bra_pkg::IDX_W-1:0]  tally;
	logic                       flag;
	logic [bra_pkg::STAT_W-1:0] status;

	modport source (output valid, found_index, tally, flag, status, input ready);
	modport sink   (input valid, found_index, tally, flag, status, output ready);
endinterface

>>> rtl/bra_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_store
// Word memory of the bit map: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bra_store #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/bitmap_range_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_range_allocator_core
// Bit map with single-bit, range, count, first/best-fit run search and allocate ops.
// ----------------------------------------------------------------------------
// The map lives in a one-port-write, registered-read word memory and is swept
// to zero word by word after reset, with no requests taken then.
// One request is in work at a time. A request walks the map one bit per cycle
// while its word buffer holds a word; each word it loads costs a step that
// finds the buffer empty, a read and a load. Setup (divide states DIVQ and
// DIVR) comes before the walk and a result state after it. Ranges walk their
// length; searches walk from position up to the hit or to the size in use.
// An allocation walks twice.
// ----------------------------------------------------------------------------
module bitmap_range_allocator_core #(
	parameter int NBITS     = 1024,
	parameter int WORD_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bra_pkg::IDX_W-1:0]  cfg_wdata,
	bra_req_if.sink                    req,
	bra_rsp_if.source                  rsp
);
	import bra_pkg::*;

	localparam int NWORDS = (NBITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int OW     = $clog2(WORD_BITS);
	localparam int SH     = 18;
	localparam int RECIP  = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
	localparam int CAP    = (NBITS > 2047) ? 2047 : NBITS;
	localparam logic [IDX_W-1:0] CAP_V  = IDX_W'(CAP);
	localparam logic [OW-1:0]    OFF_LAST = OW'(WORD_BITS - 1);
	localparam logic [AW-1:0]    CLR_LAST = AW'(NWORDS - 1);

	state_t state_q, state_d;

	logic [IDX_W-1:0]     size_cfg_q;
	logic [IDX_W-1:0]     size;
	logic [MODE_W-1:0]    mode_q;
	logic                 v_q;
	logic [IDX_W-1:0]     len_q;
	logic [CNT_W-1:0]     i_q;
	logic [IDX_W-1:0]     rem_q;
	logic [CNT_W-1:0]     wq_q;
	logic [AW-1:0]        wa_q;
	logic [OW-1:0]        off_q;
	logic [WORD_BITS-1:0] wbuf_q;
	logic                 bufv_q;
	logic                 alloc_q;
	logic [CNT_W-1:0]     run_q;
	logic [IDX_W-1:0]     rs_q;
	logic [CNT_W-1:0]     best_q;
	logic                 have_q;
	logic [IDX_W-1:0]     at_q;
	logic [IDX_W-1:0]     tally_q;
	logic                 flag_q;
	logic [IDX_W-1:0]     found_q;
	logic [STAT_W-1:0]    status_q;
	logic [AW-1:0]        clr_q;

	logic                 ov_q;
	logic [IDX_W-1:0]     o_found_q;
	logic [IDX_W-1:0]     o_tally_q;
	logic                 o_flag_q;
	logic [STAT_W-1:0]    o_status_q;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [WORD_BITS-1:0] mem_rdata;

	// request decode
	logic acc, a_single, a_range, a_search, a_bounds, a_short;
	// walk
	logic ranged, writer, rng_end, sr_end, wrap, b, nbit, match, cand, ff_hit, done_load;
	logic [WORD_BITS-1:0] nbuf;
	logic [CNT_W-1:0]     run_n;
	logic [IDX_W-1:0]     ff_at;
	logic [CNT_W+SH-1:0]  qprod;
	logic [CNT_W-1:0]     wmul;

	assign size = (size_cfg_q > CAP_V) ? CAP_V : size_cfg_q;

	always_comb begin
		acc      = (state_q == S_IDLE) && req.valid;
		a_single = req.mode <= MODE_TEST_BIT;
		a_range  = (req.mode >= MODE_SET_RANGE) && (req.mode <= MODE_CONTAINS);
		a_search = (req.mode >= MODE_FIRST_FIT) && (req.mode <= MODE_ALLOC);
		a_bounds = (a_single && (req.position >= size))
		        || (a_range && ((req.position > size) || (req.length > size - req.position)))
		        || (a_search && (req.position > size));
		a_short  = (a_range && (req.length == '0))
		        || (a_search && (req.length > size))
		        || (a_search && (req.mode != MODE_BEST_FIT) && (req.length == '0));
	end

	always_comb begin
		ranged  = alloc_q || (mode_q <= MODE_CONTAINS);
		writer  = alloc_q || (mode_q == MODE_SET_BIT) || (mode_q == MODE_FLIP_BIT)
		       || (mode_q == MODE_SET_RANGE);
		rng_end = ranged && (rem_q == '0);
		sr_end  = !ranged && (i_q == {1'b0, size});
		wrap    = (off_q == OFF_LAST);
		b       = wbuf_q[off_q];
		match   = (b == v_q);
		nbit    = (mode_q == MODE_FLIP_BIT && !alloc_q) ? ~b : v_q;
		nbuf    = wbuf_q;
		if (writer) begin
			nbuf[off_q] = nbit;
		end
		run_n   = match ? run_q + 1'b1 : '0;
		ff_hit  = run_n >= {1'b0, len_q};
		ff_at   = IDX_W'(i_q + 1'b1 - {1'b0, len_q});
		cand    = (run_q != '0) && (run_q >= {1'b0, len_q}) && (!have_q || run_q < best_q);
		qprod   = (CNT_W+SH)'(i_q) * (CNT_W+SH)'(RECIP);
		wmul    = wq_q * CNT_W'(WORD_BITS);
		done_load = !ov_q || rsp.ready;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR:   if (clr_q == CLR_LAST) state_d = S_IDLE;
			S_IDLE:  begin
				if (acc) begin
					if (!(a_single || a_range || a_search) || a_bounds || a_short)
						state_d = S_DONE;
					else
						state_d = S_DIVQ;
				end
			end
			S_DIVQ:  state_d = S_DIVR;
			S_DIVR:  state_d = S_STEP;
			S_FETCH: state_d = S_LOAD;
			S_LOAD:  state_d = S_STEP;
			S_STEP:  begin
				if (rng_end || sr_end)
					state_d = S_DONE;
				else if (!bufv_q)
					state_d = S_FETCH;
				else if (!ranged && mode_q != MODE_BEST_FIT && ff_hit)
					state_d = (mode_q == MODE_ALLOC) ? S_DIVQ : S_DONE;
			end
			S_DONE:  if (done_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == S_IDLE);
		mem_we    = 1'b0;
		mem_waddr = wa_q;
		mem_wdata = nbuf;
		unique case (state_q)
			S_CLR:  begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_STEP: begin
				if (rng_end) begin
					mem_we    = writer && bufv_q;
					mem_wdata = wbuf_q;
				end else if (!sr_end && bufv_q && ranged) begin
					mem_we = writer && wrap;
				end
			end
			default: mem_we = 1'b0;
		endcase
	end

	bra_store #(
		.DEPTH (NWORDS),
		.WIDTH (WORD_BITS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (wa_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			size_cfg_q <= SIZE_RESET;
			clr_q      <= '0;
			ov_q       <= 1'b0;
			bufv_q     <= 1'b0;
			alloc_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) size_cfg_q <= cfg_wdata;
			if (ov_q && rsp.ready && state_q != S_DONE) ov_q <= 1'b0;
			unique case (state_q)
				S_CLR:  clr_q <= clr_q + 1'b1;
				S_IDLE: begin
					if (acc) begin
						mode_q   <= req.mode;
						v_q      <= req.bit_value;
						len_q    <= req.length;
						i_q      <= {1'b0, req.position};
						rem_q    <= a_single ? IDX_W'(1) : req.length;
						bufv_q   <= 1'b0;
						alloc_q  <= 1'b0;
						run_q    <= '0;
						have_q   <= 1'b0;
						tally_q  <= '0;
						flag_q   <= 1'b0;
						status_q <= a_bounds ? ST_BOUNDS
						          : (a_search && req.length > size) ? ST_NONE : ST_OK;
						found_q  <= (a_search && !a_bounds && req.length == '0
						             && req.mode != MODE_BEST_FIT) ? req.position : '0;
					end
				end
				S_DIVQ: wq_q <= qprod[CNT_W+SH-1:SH];
				S_DIVR: begin
					wa_q  <= AW'(wq_q);
					off_q <= OW'(i_q - wmul);
				end
				S_LOAD: begin
					wbuf_q <= mem_rdata;
					bufv_q <= 1'b1;
				end
				S_STEP: begin
					if (rng_end) begin
						bufv_q <= 1'b0;
					end else if (sr_end) begin
						bufv_q <= 1'b0;
						if (mode_q == MODE_BEST_FIT) begin
							if (cand) found_q <= rs_q;
							else if (have_q) found_q <= at_q;
							else status_q <= ST_NONE;
						end else begin
							status_q <= ST_NONE;
						end
					end else if (bufv_q) begin
						wbuf_q <= nbuf;
						i_q    <= (!ranged && mode_q == MODE_ALLOC && ff_hit)
						          ? {1'b0, ff_at} : i_q + 1'b1;
						off_q  <= wrap ? '0 : off_q + 1'b1;
						if (wrap) begin
							wa_q <= wa_q + 1'b1;
						end
						if (wrap || (!ranged && mode_q != MODE_BEST_FIT && ff_hit)) begin
							bufv_q <= 1'b0;
						end
						if (ranged) begin
							rem_q <= rem_q - 1'b1;
							if (!alloc_q && mode_q == MODE_TEST_BIT) flag_q <= b;
							if (!alloc_q && (mode_q == MODE_COUNT || mode_q == MODE_CONTAINS)
							    && match)
								tally_q <= tally_q + 1'b1;
						end else if (mode_q == MODE_BEST_FIT) begin
							if (match) begin
								if (run_q == '0) rs_q <= IDX_W'(i_q);
								run_q <= run_q + 1'b1;
							end else begin
								if (cand) begin
									have_q <= 1'b1;
									best_q <= run_q;
									at_q   <= rs_q;
								end
								run_q <= '0;
							end
						end else begin
							run_q <= run_n;
							if (ff_hit) begin
								found_q <= ff_at;
								if (mode_q == MODE_ALLOC) begin
									alloc_q <= 1'b1;
									v_q     <= ~v_q;
									rem_q   <= len_q;
								end
							end
						end
					end
				end
				S_DONE: begin
					if (done_load) begin
						ov_q       <= 1'b1;
						o_found_q  <= found_q;
						o_tally_q  <= (mode_q == MODE_CONTAINS) ? '0 : tally_q;
						o_flag_q   <= (mode_q == MODE_CONTAINS) ? (tally_q != '0) : flag_q;
						o_status_q <= status_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.found_index = o_found_q;
	assign rsp.tally       = o_tally_q;
	assign rsp.flag        = o_flag_q;
	assign rsp.status      = o_status_q;

endmodule

>>> rtl/bra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_checker
// Port-level checks of the bitmap range allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bra_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [bra_pkg::IDX_W-1:0]  out_found,
	input logic [bra_pkg::IDX_W-1:0]  out_tally,
	input logic                       out_flag,
	input logic [bra_pkg::STAT_W-1:0] out_status
);
	import bra_pkg::*;

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while another is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_status == ST_OK || out_status == ST_NONE
		               || out_status == ST_BOUNDS))
		else $error("undefined status code");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_status != ST_OK) |->
		(out_found == '0 && out_tally == '0 && !out_flag))
		else $error("failed request carries data");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_status)
		                               && $stable(out_found)))
		else $error("stalled response changed");

endmodule

bind bitmap_range_allocator_core bra_checker u_bra_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_found  (rsp.found_index),
	.out_tally  (rsp.tally),
	.out_flag   (rsp.flag),
	.out_status (rsp.status)
);

>>> tb/sv/tb_bitmap_range_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_range_allocator_core
// Self-checking bench for the bitmap range allocator core.
// ----------------------------------------------------------------------------
// Requests are queued by a stimulus process and driven with random gaps; every
// response is checked field by field against a software copy of the bit map
// that is updated as each request is accepted. The size register is changed
// between phases only once the core is idle, including its extremes.
// ----------------------------------------------------------------------------
module tb_bitmap_range_allocator_core;
	import bra_pkg::*;

	localparam int NBITS = 1024;
	localparam int CYCLE_LIMIT = 20000000;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  position;
		logic [IDX_W-1:0]  length;
		logic              bit_value;
	} bra_req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  found_index;
		logic [IDX_W-1:0]  tally;
		logic              flag;
		logic [STAT_W-1:0] status;
	} bra_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_wdata = '0;

	bra_req_if req ();
	bra_rsp_if rsp ();

	bitmap_range_allocator_core #(.NBITS(NBITS), .WORD_BITS(32)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req.sink),
		.rsp       (rsp.source)
	);

	always #5 clk = ~clk;

	bit       map_bits [NBITS];
	int       map_size;
	bra_req_t pending_reqs[$];
	bra_rsp_t expected_rsps[$];
	int       mismatches = 0;
	int       req_gap = 0;
	int       rsp_gap = 0;
	bit       req_taken = 1'b0;
	longint   cycles = 0;

	function automatic int eff_size();
		return (map_size > NBITS) ? NBITS : map_size;
	endfunction

	function automatic bra_rsp_t apply_request(bra_req_t r);
		bra_rsp_t o;
		int sz, p, n, run, rs, best, at;
		bit have;
		o = '0;
		sz = eff_size();
		p = r.position;
		n = r.length;
		case (r.mode)
			MODE_SET_BIT, MODE_FLIP_BIT, MODE_TEST_BIT: begin
				if (p >= sz) o.status = ST_BOUNDS;
				else if (r.mode == MODE_SET_BIT) map_bits[p] = r.bit_value;
				else if (r.mode == MODE_FLIP_BIT) map_bits[p] = ~map_bits[p];
				else o.flag = map_bits[p];
			end
			MODE_SET_RANGE, MODE_COUNT, MODE_CONTAINS: begin
				if (p + n > sz) o.status = ST_BOUNDS;
				else begin
					run = 0;
					for (int i = 0; i < n; i++) begin
						if (r.mode == MODE_SET_RANGE) map_bits[p+i] = r.bit_value;
						else if (map_bits[p+i] == r.bit_value) run++;
					end
					if (r.mode == MODE_COUNT) o.tally = IDX_W'(run);
					if (r.mode == MODE_CONTAINS) o.flag = (run != 0);
				end
			end
			MODE_FIRST_FIT, MODE_BEST_FIT, MODE_ALLOC: begin
				have = 0;
				at = 0;
				if (p > sz) o.status = ST_BOUNDS;
				else begin
					if (n <= sz) begin
						if (r.mode == MODE_BEST_FIT) begin
							run = 0; rs = 0; best = 0;
							for (int i = p; i <= sz; i++) begin
								if (i < sz && map_bits[i] == r.bit_value) begin
									if (run == 0) rs = i;
									run++;
								end else begin
									if (run > 0 && run >= n && (!have || run < best)) begin
										have = 1; best = run; at = rs;
									end
									run = 0;
								end
							end
						end else if (n == 0) begin
							have = 1; at = p;
						end else begin
							run = 0;
							for (int i = p; i < sz && !have; i++) begin
								run = (map_bits[i] == r.bit_value) ? run + 1 : 0;
								if (run >= n) begin
									have = 1; at = i + 1 - n;
								end
							end
						end
					end
					if (!have) o.status = ST_NONE;
					else begin
						o.found_index = IDX_W'(at);
						if (r.mode == MODE_ALLOC)
							for (int i = 0; i < n; i++) map_bits[at+i] = ~r.bit_value;
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_taken) begin
				req_taken = 1'b0;
				req.valid <= 1'b0;
				req_gap = $urandom_range(0, 19);
				if ($urandom_range(0, 3) == 0) req_gap = 0;
			end else if (!req.valid && pending_reqs.size() > 0) begin
				if (req_gap > 0) req_gap--;
				else begin
					bra_req_t r;
					r = pending_reqs.pop_front();
					req.mode <= r.mode;
					req.position <= r.position;
					req.length <= r.length;
					req.bit_value <= r.bit_value;
					req.valid <= 1'b1;
				end
			end
			if (rsp_gap > 0) begin
				rsp_gap--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (req.valid && req.ready) begin
				bra_req_t r;
				r = {req.mode, req.position, req.length, req.bit_value};
				expected_rsps.push_back(apply_request(r));
				req_taken = 1'b1;
			end
			if (rsp.valid && rsp.ready) begin
				bra_rsp_t got, want;
				got = {rsp.found_index, rsp.tally, rsp.flag, rsp.status};
				if ($urandom_range(0, 2) == 0) rsp_gap = $urandom_range(0, 19);
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected word %h", got);
				end else begin
					want = expected_rsps.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp idx=%0d tally=%0d flag=%0b st=%0d, got idx=%0d tally=%0d flag=%0b st=%0d",
								want.found_index, want.tally, want.flag, want.status,
								got.found_index, got.tally, got.flag, got.status);
					end
				end
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic push(input logic [MODE_W-1:0] m, input int p, input int n, input bit v);
		bra_req_t r;
		r.mode = m;
		r.position = IDX_W'(p);
		r.length = IDX_W'(n);
		r.bit_value = v;
		pending_reqs.push_back(r);
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	task automatic write_size(input int s);
		@(negedge clk);
		cfg_wdata <= IDX_W'(s);
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		map_size = s & 11'h7ff;
	endtask

	task automatic random_phase(input int count);
		int sz, m, p, n;
		for (int k = 0; k < count; k++) begin
			sz = eff_size();
			m = $urandom_range(0, 99);
			if (m < 4) m = $urandom_range(9, 15);
			else m = $urandom_range(0, 8);
			case ($urandom_range(0, 9))
				0: p = $urandom_range(0, 2047);
				1: p = sz;
				default: p = (sz > 0) ? $urandom_range(0, sz - 1) : 0;
			endcase
			case ($urandom_range(0, 9))
				0: n = $urandom_range(0, 2047);
				1: n = 0;
				2, 3: n = (p < sz) ? sz - p : $urandom_range(0, 40);
				default: n = $urandom_range(1, 24);
			endcase
			if (m == MODE_SET_RANGE && $urandom_range(0, 1) && p < sz && sz - p > 0)
				n = $urandom_range(1, (sz - p < 200) ? sz - p : 200);
			push(MODE_W'(m), p, n, 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 30) == 0) while (pending_reqs.size() > 0) @(posedge clk);
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.mode = '0;
		req.position = '0;
		req.length = '0;
		req.bit_value = 1'b0;
		rsp.ready = 1'b0;
		map_size = SIZE_RESET;
		foreach (map_bits[i]) map_bits[i] = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push(MODE_TEST_BIT, 0, 0, 0);
		push(MODE_SET_BIT, 0, 0, 1);
		push(MODE_SET_BIT, 1023, 0, 1);
		push(MODE_FLIP_BIT, 5, 0, 0);
		push(MODE_TEST_BIT, 1023, 0, 0);
		push(MODE_TEST_BIT, 1024, 0, 0);
		push(MODE_FLIP_BIT, 2047, 0, 0);
		push(MODE_SET_RANGE, 100, 50, 1);
		push(MODE_SET_RANGE, 1000, 25, 1);
		push(MODE_COUNT, 0, 1024, 1);
		push(MODE_COUNT, 90, 70, 0);
		push(MODE_CONTAINS, 200, 0, 1);
		push(MODE_CONTAINS, 0, 1024, 1);
		push(MODE_FIRST_FIT, 0, 40, 1);
		push(MODE_FIRST_FIT, 1024, 0, 0);
		push(MODE_FIRST_FIT, 1025, 1, 0);
		push(MODE_FIRST_FIT, 0, 1025, 0);
		push(MODE_BEST_FIT, 0, 0, 1);
		push(MODE_BEST_FIT, 120, 3, 1);
		push(MODE_BEST_FIT, 0, 2000, 1);
		push(MODE_ALLOC, 0, 30, 0);
		push(MODE_ALLOC, 0, 0, 0);
		push(MODE_ALLOC, 0, 1024, 0);
		push(MODE_SET_BIT, 2047, 2047, 1);
		push(4'd15, 2047, 2047, 1);
		drain();

		write_size(0);
		random_phase(60);
		drain();
		write_size(2047);
		random_phase(300);
		drain();
		write_size(77);
		random_phase(500);
		drain();
		write_size(1);
		random_phase(60);
		drain();
		write_size(1024);
		random_phase(400);
		drain();
		write_size(300);
		random_phase(400);
		drain();

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/bra_pkg.sv
rtl/bra_if.sv
rtl/bra_store.sv
rtl/bitmap_range_allocator_core.sv
rtl/bra_checker.sv
tb/sv/tb_bitmap_range_allocator_core.sv
